// ===== hw/rtl/sine_contrast_waveshaper_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sine contrast waveshaper
// Shared property shapes, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SINE_CONTRAST_WAVESHAPER_UNIT_DEFINES_SVH
`define SINE_CONTRAST_WAVESHAPER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scw_pkg.sv =====
// ----------------------------------------------------------------------------
// scw_pkg
// Widths, constants and the quarter-wave table generator.
// ----------------------------------------------------------------------------
package scw_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int SAMPLE_W   = 32;
  localparam int PHASE_W    = 33;          // 2^33 is one full turn
  localparam int TAB_W      = 31;          // Q1.30 magnitude in [0, 2^30]
  localparam int GAIN_W     = 14;
  localparam int GAINK_W    = 33;          // gain times offset constant
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int OFF_SHIFT  = 34;

  localparam logic [63:0]         HALF_PI_Q30 = 64'd1686629713;
  localparam logic [GAINK_W-1:0]  OFFSET_K    = GAINK_W'(333772);
  localparam logic [GAIN_W-1:0]   GAIN_RESET  = GAIN_W'(6554);
  localparam logic [GAINK_W-1:0]  GAINK_RESET = GAINK_W'(GAINK_W'(GAIN_RESET) * OFFSET_K);
  localparam logic [TAB_W-1:0]    ONE_Q30     = TAB_W'(64'd1 << 30);
  localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 32'h7FFF_FFFF;

  // Register index, taken from paddr[2]
  localparam logic REG_CONTRAST_GAIN = 1'b0;

  // Entry k of the quarter-wave table: Taylor series to the 13th power,
  // each term truncated, clamped to [0, 2^30].
  function automatic logic [TAB_W-1:0] sine_entry(input int k, input int bits);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    longint      sum;
    a   = (64'(k) * HALF_PI_Q30 + (64'd1 << (bits - 1))) >> bits;
    a2  = (a * a + (64'd1 << 29)) >> 30;
    sum = longint'(a);
    t   = ((a * a2) >> 30) / 64'd6;
    sum = sum - longint'(t);
    t   = ((t * a2) >> 30) / 64'd20;
    sum = sum + longint'(t);
    t   = ((t * a2) >> 30) / 64'd42;
    sum = sum - longint'(t);
    t   = ((t * a2) >> 30) / 64'd72;
    sum = sum + longint'(t);
    t   = ((t * a2) >> 30) / 64'd110;
    sum = sum - longint'(t);
    t   = ((t * a2) >> 30) / 64'd156;
    sum = sum + longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(64'd1 << 30)) begin
      sum = longint'(64'd1 << 30);
    end
    return TAB_W'(sum);
  endfunction

endpackage

// ===== hw/rtl/scw_stream_if.sv =====
// ----------------------------------------------------------------------------
// scw stream interfaces
// Valid/ready channels for input samples and shaped results.
// ----------------------------------------------------------------------------
interface scw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [scw_pkg::SAMPLE_W-1:0] sample_in;
  logic                                last_in;

  modport source (output valid, sample_in, last_in, input ready);
  modport sink   (input valid, sample_in, last_in, output ready);
endinterface

interface scw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [scw_pkg::SAMPLE_W-1:0] sample_out;
  logic                                last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink   (input valid, sample_out, last_out, output ready);
endinterface

// ===== hw/rtl/scw_ram.sv =====
// ----------------------------------------------------------------------------
// scw_ram
// Generic RAM: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module scw_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== hw/rtl/scw_table_fill.sv =====
// ----------------------------------------------------------------------------
// scw_table_fill
// Sweeps the quarter-wave table into the sine RAMs after reset.
// ----------------------------------------------------------------------------
module scw_table_fill #(
  parameter int TABLE_BITS = scw_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       we,
  output logic [TABLE_BITS:0]        addr,
  output logic [scw_pkg::TAB_W-1:0]  data,
  output logic                       done
);
  import scw_pkg::*;

  localparam int N     = 1 << TABLE_BITS;
  localparam int DEPTH = N + 1;
  localparam int AW    = TABLE_BITS + 1;

  typedef enum logic {FILL, RUN} fill_state_t;

  fill_state_t      state;
  logic [TAB_W-1:0] tab [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    localparam logic [TAB_W-1:0] ENTRY = sine_entry(k, TABLE_BITS);
    assign tab[k] = ENTRY;
  end

  assign we   = (state == FILL);
  assign done = (state == RUN);
  assign data = tab[addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FILL;
      addr  <= '0;
    end else begin
      case (state)
        FILL: begin
          if (addr == AW'(N)) begin
            state <= RUN;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        RUN: begin
          state <= RUN;
        end
        default: begin
          state <= FILL;
          addr  <= '0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/scw_sine.sv =====
// ----------------------------------------------------------------------------
// scw_sine
// Three-stage sine of a 33-bit phase: table read, step multiply, interpolate.
// ----------------------------------------------------------------------------
module scw_sine #(
  parameter int TABLE_BITS = scw_pkg::SINE_TABLE_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fill_we,
  input  logic [TABLE_BITS:0]         fill_addr,
  input  logic [scw_pkg::TAB_W-1:0]   fill_data,
  input  logic                        in_valid,
  input  logic [scw_pkg::PHASE_W-1:0] phase,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        up_en,
  input  logic                        dn_en,
  output logic                        out_valid,
  output logic                        out_neg,
  output logic [scw_pkg::TAB_W-1:0]   out_mag,
  output logic [SIDE_W-1:0]           out_side
);
  import scw_pkg::*;

  localparam int N      = 1 << TABLE_BITS;
  localparam int AW     = TABLE_BITS + 1;
  localparam int MIR_W  = PHASE_W - 1;
  localparam int FRAC   = MIR_W - AW;
  localparam int PROD_W = TAB_W + FRAC;

  logic [1:0]       quad;
  logic [MIR_W-1:0] r_raw;
  logic [MIR_W-1:0] r;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    idx1;
  logic             en_a, en_b, en_c;

  logic             va, vb, vc;
  logic [TAB_W-1:0] t0, t1;
  logic [FRAC-1:0]  a_frac;
  logic             a_neg;
  logic [SIDE_W-1:0] a_side;

  logic [TAB_W-1:0]  diff;
  logic              down;
  logic [PROD_W-1:0] b_prod;
  logic [TAB_W-1:0]  b_t0;
  logic              b_down, b_neg;
  logic [SIDE_W-1:0] b_side;

  logic [TAB_W-1:0]  step;

  // Mirror odd quadrants; an index of N reads entry N with zero fraction
  assign quad  = phase[PHASE_W-1 -: 2];
  assign r_raw = {1'b0, phase[PHASE_W-3:0]};
  assign r     = quad[0] ? ((MIR_W'(1) << (MIR_W - 1)) - r_raw) : r_raw;
  assign idx   = r[MIR_W-1:FRAC];
  assign idx1  = (idx == AW'(N)) ? idx : idx + AW'(1);

  assign en_c  = !vc || dn_en;
  assign en_b  = !vb || en_c;
  assign en_a  = !va || en_b;
  assign up_en = en_a;

  scw_ram #(.WIDTH(TAB_W), .DEPTH(N + 1)) u_tab (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (en_a),
    .raddr0(idx),
    .raddr1(idx1),
    .rdata0(t0),
    .rdata1(t1)
  );

  assign down = (t1 < t0);
  assign diff = down ? (t0 - t1) : (t1 - t0);
  assign step = TAB_W'(b_prod >> FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_frac <= r[FRAC-1:0];
      a_neg  <= quad[1];
      a_side <= in_side;
    end
    if (en_b) begin
      b_prod <= PROD_W'(diff) * PROD_W'(a_frac);
      b_t0   <= t0;
      b_down <= down;
      b_neg  <= a_neg;
      b_side <= a_side;
    end
    if (en_c) begin
      out_mag  <= b_down ? (b_t0 - step) : (b_t0 + step);
      out_neg  <= b_neg;
      out_side <= b_side;
    end
  end

  assign out_valid = vc;

endmodule

// ===== hw/rtl/sine_contrast_waveshaper_unit.sv =====
// ----------------------------------------------------------------------------
// sine_contrast_waveshaper_unit
// Per-sample contrast waveshaper: sin(d + g * sin(4d)) at 32-bit full scale.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   samples   in         valid / ready    sample_in[31:0] signed, last_in
//   shaped    out        valid / ready    sample_out[31:0] signed, last_out
//   APB       in         psel & penable   contrast_gain at byte address 0
//
// One sample per cycle while shaped.ready is high and the fill is done;
// three stages per sine lookup (table RAM read, step multiply, interpolate),
// two for the gain offset (33x31 multiply, round and phase add), one for output scaling.
// After reset the table is swept into both sine RAMs, one entry a cycle:
// 2^SINE_TABLE_BITS + 1 entries, with samples.ready low; APB writes are taken.
// Each stage holds its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up and a stalled result keeps its slot.
// ----------------------------------------------------------------------------
module sine_contrast_waveshaper_unit #(
  parameter int SINE_TABLE_BITS = scw_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [scw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  scw_in_if.sink                         samples,
  scw_out_if.source                      shaped
);
  import scw_pkg::*;

  `include "sine_contrast_waveshaper_unit_defines.svh"

  localparam int SIDE_A_W = PHASE_W + 1;
  localparam int P4_W     = GAINK_W + TAB_W;
  localparam int SCALE_W  = TAB_W + 31;

  // Configuration
  logic [GAIN_W-1:0]  contrast_gain;
  logic [GAINK_W-1:0] gain_k;
  logic               cfg_write;

  // Table fill
  logic                     fill_we;
  logic [SINE_TABLE_BITS:0] fill_addr;
  logic [TAB_W-1:0]         fill_data;
  logic                     fill_done;

  // Sine of 4d
  logic [PHASE_W-1:0]  phase4;
  logic [SIDE_A_W-1:0] side_a_in, side_a_out;
  logic                up_en_a, va_out, neg_a;
  logic [TAB_W-1:0]    mag_a;

  // Offset stages
  logic                en4, en5, v4, v5;
  logic [P4_W-1:0]     p4;
  logic                neg4;
  logic [PHASE_W-1:0]  x4;
  logic                last4;
  logic [P4_W-1:0]     rnd;
  logic [PHASE_W-1:0]  off;
  logic [PHASE_W-1:0]  total5;
  logic                last5;

  // Sine of the shaped angle
  logic                up_en_b, vb_out, neg_b, last_b;
  logic [TAB_W-1:0]    mag_b;

  // Output stage
  logic                en_o, v_o;
  logic [SCALE_W-1:0]  scaled_full;
  logic [SAMPLE_W-1:0] scaled, clamped;
  logic [SAMPLE_W-1:0] o_sample;
  logic                o_last;

  // ---------------------------------------------------------------------------
  // APB register: keep gain times the radian-to-phase constant alongside it
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CONTRAST_GAIN) ? CFG_DATA_W'(contrast_gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_gain <= GAIN_RESET;
      gain_k        <= GAINK_RESET;
    end else if (cfg_write && (paddr[2] == REG_CONTRAST_GAIN)) begin
      contrast_gain <= pwdata[GAIN_W-1:0];
      gain_k        <= GAINK_W'(GAINK_W'(pwdata[GAIN_W-1:0]) * OFFSET_K);
    end
  end

  // ---------------------------------------------------------------------------
  // Table sweep after reset
  // ---------------------------------------------------------------------------
  scw_table_fill #(.TABLE_BITS(SINE_TABLE_BITS)) u_fill (
    .clk (clk),
    .rst (rst),
    .we  (fill_we),
    .addr(fill_addr),
    .data(fill_data),
    .done(fill_done)
  );

  // ---------------------------------------------------------------------------
  // sin(4d): phase of 4d is the sample shifted up two places, wrapping a turn
  // ---------------------------------------------------------------------------
  assign phase4    = {samples.sample_in[SAMPLE_W-2:0], 2'b00};
  assign side_a_in = {samples.last_in, samples.sample_in[SAMPLE_W-1], samples.sample_in};
  assign samples.ready = up_en_a && fill_done;

  scw_sine #(.TABLE_BITS(SINE_TABLE_BITS), .SIDE_W(SIDE_A_W)) u_sine_a (
    .clk      (clk),
    .rst      (rst),
    .fill_we  (fill_we),
    .fill_addr(fill_addr),
    .fill_data(fill_data),
    .in_valid (samples.valid && fill_done),
    .phase    (phase4),
    .in_side  (side_a_in),
    .up_en    (up_en_a),
    .dn_en    (en4),
    .out_valid(va_out),
    .out_neg  (neg_a),
    .out_mag  (mag_a),
    .out_side (side_a_out)
  );

  // ---------------------------------------------------------------------------
  // Offset: multiply, then round to phase units and add with the sine's sign
  // ---------------------------------------------------------------------------
  assign en5 = !v5 || up_en_b;
  assign en4 = !v4 || en5;
  assign rnd = p4 + (P4_W'(1) << (OFF_SHIFT - 1));
  assign off = PHASE_W'(rnd[P4_W-1:OFF_SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= va_out;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      p4    <= P4_W'(gain_k) * P4_W'(mag_a);
      neg4  <= neg_a;
      x4    <= side_a_out[PHASE_W-1:0];
      last4 <= side_a_out[SIDE_A_W-1];
    end
    if (en5) begin
      total5 <= neg4 ? (x4 - off) : (x4 + off);
      last5  <= last4;
    end
  end

  // ---------------------------------------------------------------------------
  // sin(d + g * sin(4d))
  // ---------------------------------------------------------------------------
  scw_sine #(.TABLE_BITS(SINE_TABLE_BITS), .SIDE_W(1)) u_sine_b (
    .clk      (clk),
    .rst      (rst),
    .fill_we  (fill_we),
    .fill_addr(fill_addr),
    .fill_data(fill_data),
    .in_valid (v5),
    .phase    (total5),
    .in_side  (last5),
    .up_en    (up_en_b),
    .dn_en    (en_o),
    .out_valid(vb_out),
    .out_neg  (neg_b),
    .out_mag  (mag_b),
    .out_side (last_b)
  );

  // ---------------------------------------------------------------------------
  // Output: m * (2^31 - 1) >> 30, clamp to full scale, reapply the sign
  // ---------------------------------------------------------------------------
  assign en_o        = !v_o || shaped.ready;
  assign scaled_full = {mag_b, 31'b0} - SCALE_W'(mag_b);
  assign scaled      = scaled_full[SCALE_W-1:SCALE_W-SAMPLE_W];
  assign clamped     = (scaled > FULL_SCALE) ? FULL_SCALE : scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en_o) begin
      v_o <= vb_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_sample <= neg_b ? (SAMPLE_W'(0) - clamped) : clamped;
      o_last   <= last_b;
    end
  end

  assign shaped.valid      = v_o;
  assign shaped.sample_out = o_sample;
  assign shaped.last_out   = o_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SCW_ASSERT_SAME(a_fill_quiet, fill_we, !v4 && !v5 && !v_o, "sample in flight during table fill")
  `SCW_ASSERT_NEXT(a_gain_k, cfg_write, gain_k == GAINK_W'(GAINK_W'(contrast_gain) * OFFSET_K), "gain product out of step")
  `SCW_ASSERT_SAME(a_mag_range, va_out, mag_a <= ONE_Q30, "interpolated sine above unity")
  `SCW_ASSERT_SAME(a_no_min, v_o, o_sample != ~FULL_SCALE, "output reached negative full scale")

endmodule
